>>> hdl/mdc_pkg.sv
// Shared types and constants of the depth-first maze carver.
`timescale 1ns / 1ps
`default_nettype none
package mdc_pkg;

  // Widths of the fixed word fields.
  localparam int unsigned CoordW   = 5;
  localparam int unsigned DirW     = 2;
  localparam int unsigned KindW    = 3;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned CfgIdxW  = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 1'b1;

  // Directions of a move.
  localparam logic [DirW-1:0] DIR_UP    = 2'd0;
  localparam logic [DirW-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DirW-1:0] DIR_RIGHT = 2'd2;
  localparam logic [DirW-1:0] DIR_DOWN  = 2'd3;

  // Event codes of a result word.
  localparam logic [KindW-1:0] EV_STARTED     = 3'd0;
  localparam logic [KindW-1:0] EV_CARVED      = 3'd1;
  localparam logic [KindW-1:0] EV_BLOCKED     = 3'd2;
  localparam logic [KindW-1:0] EV_BACKTRACKED = 3'd3;
  localparam logic [KindW-1:0] EV_FINISHED    = 3'd4;

  typedef struct packed {
    logic [DirW-1:0]   pick_direction;
    logic [CoordW-1:0] start_column;
    logic [CoordW-1:0] start_row;
  } in_word_t;

  typedef struct packed {
    logic [KindW-1:0]  event_kind;
    logic [CoordW-1:0] from_column;
    logic [CoordW-1:0] from_row;
    logic [CoordW-1:0] to_column;
    logic [CoordW-1:0] to_row;
    logic [DirW-1:0]   carved_direction;
    logic              maze_done;
  } out_word_t;

endpackage
`default_nettype wire

>>> hdl/maze_dfs_carver.sv
// Randomized depth-first maze carver: sequencer, visited map and path stack.
`timescale 1ns / 1ps
`default_nettype none
// The carver builds a maze by the recursive backtracker scheme, one input word
// per iteration and exactly one result word per input word. After reset the
// visited map is swept clear, one cell per cycle, over all
// 2**(clog2(MAX_COLUMNS) + clog2(MAX_ROWS)) entries (1024 with the default
// grid); no input word is taken during that sweep, while configuration writes
// are taken as ever. A word that starts the maze or arrives after it is
// finished goes only through the dispatch and emit states. For any other word
// the top of the path stack is read from its memory, then the four neighbour
// visited bits are read one after another through the single read port of
// the visited map, each checked by one shared neighbour unit, and that same
// unit then forms the carve target. The block takes one word at a time; a
// finished result waits in the output register while the next word is already
// accepted and worked on. The user must write grid size registers only while
// the block is idle; the block does not enforce it. A size of zero counts as
// one and a size above the grid maximum counts as that maximum.
module maze_dfs_carver #(
  parameter int unsigned MAX_COLUMNS = 32,
  parameter int unsigned MAX_ROWS    = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire mdc_pkg::in_word_t             in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mdc_pkg::out_word_t                 out_word_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mdc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mdc_pkg::*;

  // Column and row coordinate widths, and the width used for compares against
  // the grid size (wide enough for the 6-bit registers and for the maximum).
  localparam int unsigned CW     = $clog2(MAX_COLUMNS);
  localparam int unsigned RW     = $clog2(MAX_ROWS);
  localparam int unsigned DimCW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned DimRW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned DimMax = (DimCW > DimRW) ? DimCW : DimRW;
  localparam int unsigned DIM_W  = (DimMax > CfgDataW) ? DimMax : CfgDataW;
  localparam int unsigned VA_W   = CW + RW;
  localparam int unsigned VIS_DEPTH = 2 ** VA_W;
  localparam int unsigned CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned SA_W   = $clog2(CELLS);
  localparam int unsigned SD_W   = $clog2(CELLS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_TOP,
    ST_NB_ADDR,
    ST_NB_CHK,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  function automatic logic [CoordW-1:0] fit5(input logic [DIM_W-1:0] v);
    fit5 = v[CoordW-1:0];
  endfunction

  // Control and payload registers.
  state_e                 state_q, state_d;
  logic [DirW-1:0]        pick_q, pick_d;
  logic [CoordW-1:0]      scol_q, scol_d;
  logic [CoordW-1:0]      srow_q, srow_d;
  logic [CW-1:0]          cur_col_q, cur_col_d;
  logic [RW-1:0]          cur_row_q, cur_row_d;
  logic [DirW-1:0]        dir_q, dir_d;
  logic                   nb_ok_q, nb_ok_d;
  logic [3:0]             open_q, open_d;
  logic [SD_W-1:0]        depth_q, depth_d;
  logic                   done_q, done_d;
  logic [CfgDataW-1:0]    width_q, width_d;
  logic [CfgDataW-1:0]    height_q, height_d;
  logic [VA_W-1:0]        clr_q, clr_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_q, out_d;
  out_word_t              res_q, res_d;

  // Memories and their ports.
  logic                   vis_mem [VIS_DEPTH];
  logic [VA_W-1:0]        stk_mem [CELLS];
  logic                   vis_rd_q;
  logic [VA_W-1:0]        stk_rd_q;
  logic                   vis_we;
  logic [VA_W-1:0]        vis_waddr;
  logic                   vis_wdata;
  logic                   stk_we;
  logic [SA_W-1:0]        stk_waddr;
  logic [VA_W-1:0]        stk_wdata;
  logic [SA_W-1:0]        stk_raddr;

  // Effective grid size.
  logic [DIM_W-1:0]       w_eff;
  logic [DIM_W-1:0]       h_eff;

  // Shared neighbour unit.
  logic [DirW-1:0]        nb_dir;
  logic [DIM_W-1:0]       nb_x;
  logic [DIM_W-1:0]       nb_y;
  logic                   nb_step_ok;
  logic                   nb_ok;
  logic [VA_W-1:0]        nb_addr;

  // Start cell after saturation.
  logic [DIM_W-1:0]       st_col;
  logic [DIM_W-1:0]       st_row;
  logic [DIM_W-1:0]       sc_ext;
  logic [DIM_W-1:0]       sr_ext;

  logic                   out_free;
  logic                   any_open;
  logic [SD_W-1:0]        depth_dec;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(width_q) > DIM_W'(MAX_COLUMNS)) begin
      w_eff = DIM_W'(MAX_COLUMNS);
    end else begin
      w_eff = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(height_q) > DIM_W'(MAX_ROWS)) begin
      h_eff = DIM_W'(MAX_ROWS);
    end else begin
      h_eff = DIM_W'(height_q);
    end
  end

  // Start cell, saturated to the last column and row in use.
  always_comb begin
    sc_ext = DIM_W'(scol_q);
    sr_ext = DIM_W'(srow_q);
    st_col = (sc_ext > (w_eff - 1'b1)) ? (w_eff - 1'b1) : sc_ext;
    st_row = (sr_ext > (h_eff - 1'b1)) ? (h_eff - 1'b1) : sr_ext;
  end

  // One neighbour unit serves the four probes and the final carve: it steps
  // the current cell in one direction and checks the result against the grid.
  assign nb_dir = (state_q == ST_DECIDE) ? pick_q : dir_q;

  always_comb begin
    nb_x       = DIM_W'(cur_col_q);
    nb_y       = DIM_W'(cur_row_q);
    nb_step_ok = 1'b1;
    case (nb_dir)
      DIR_UP: begin
        nb_step_ok = (cur_row_q != '0);
        nb_y       = DIM_W'(cur_row_q) - 1'b1;
      end
      DIR_LEFT: begin
        nb_step_ok = (cur_col_q != '0);
        nb_x       = DIM_W'(cur_col_q) - 1'b1;
      end
      DIR_RIGHT: begin
        nb_x = DIM_W'(cur_col_q) + 1'b1;
      end
      DIR_DOWN: begin
        nb_y = DIM_W'(cur_row_q) + 1'b1;
      end
      default: begin
        nb_step_ok = 1'b0;
      end
    endcase
    nb_ok   = nb_step_ok && (nb_x < w_eff) && (nb_y < h_eff);
    nb_addr = {nb_y[RW-1:0], nb_x[CW-1:0]};
  end

  assign any_open  = |open_q;
  assign depth_dec = depth_q - 1'b1;
  assign stk_raddr = SA_W'(depth_dec);

  always_comb begin
    state_d     = state_q;
    pick_d      = pick_q;
    scol_d      = scol_q;
    srow_d      = srow_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    dir_d       = dir_q;
    nb_ok_d     = nb_ok_q;
    open_d      = open_q;
    depth_d     = depth_q;
    done_d      = done_q;
    width_d     = width_q;
    height_d    = height_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    vis_we      = 1'b0;
    vis_waddr   = nb_addr;
    vis_wdata   = 1'b1;
    stk_we      = 1'b0;
    stk_waddr   = SA_W'(depth_q);
    stk_wdata   = nb_addr;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        default:    ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = 1'b0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == VA_W'(VIS_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          pick_d  = in_word_i.pick_direction;
          scol_d  = in_word_i.start_column;
          srow_d  = in_word_i.start_row;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        res_d = '0;
        if (done_q) begin
          res_d.event_kind = EV_FINISHED;
          res_d.maze_done  = 1'b1;
          state_d          = ST_EMIT;
        end else if (depth_q == '0) begin
          vis_we            = 1'b1;
          vis_waddr         = {st_row[RW-1:0], st_col[CW-1:0]};
          stk_we            = 1'b1;
          stk_waddr         = '0;
          stk_wdata         = {st_row[RW-1:0], st_col[CW-1:0]};
          depth_d           = SD_W'(1);
          res_d.event_kind  = EV_STARTED;
          res_d.from_column = fit5(st_col);
          res_d.from_row    = fit5(st_row);
          state_d           = ST_EMIT;
        end else begin
          state_d = ST_TOP;
        end
      end
      ST_TOP: begin
        cur_col_d = stk_rd_q[CW-1:0];
        cur_row_d = stk_rd_q[VA_W-1:CW];
        dir_d     = DIR_UP;
        state_d   = ST_NB_ADDR;
      end
      ST_NB_ADDR: begin
        nb_ok_d = nb_ok;
        state_d = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        // Probes shift in from the top, so direction d ends up in bit d.
        open_d = {nb_ok_q && !vis_rd_q, open_q[3:1]};
        if (dir_q == DIR_DOWN) begin
          state_d = ST_DECIDE;
        end else begin
          dir_d   = dir_q + 1'b1;
          state_d = ST_NB_ADDR;
        end
      end
      ST_DECIDE: begin
        res_d             = '0;
        res_d.from_column = fit5(DIM_W'(cur_col_q));
        res_d.from_row    = fit5(DIM_W'(cur_row_q));
        if (!any_open) begin
          depth_d = depth_dec;
          if (depth_dec == '0) begin
            done_d           = 1'b1;
            res_d.event_kind = EV_FINISHED;
            res_d.maze_done  = 1'b1;
          end else begin
            res_d.event_kind = EV_BACKTRACKED;
          end
        end else if (open_q[pick_q] && (depth_q < SD_W'(CELLS))) begin
          vis_we                 = 1'b1;
          stk_we                 = 1'b1;
          depth_d                = depth_q + 1'b1;
          res_d.event_kind       = EV_CARVED;
          res_d.to_column        = fit5(nb_x);
          res_d.to_row           = fit5(nb_y);
          res_d.carved_direction = pick_q;
        end else begin
          res_d.event_kind = EV_BLOCKED;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      depth_q     <= '0;
      done_q      <= 1'b0;
      width_q     <= CfgDataW'(32);
      height_q    <= CfgDataW'(32);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      dir_q       <= DIR_UP;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      done_q      <= done_d;
      width_q     <= width_d;
      height_q    <= height_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      dir_q       <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q    <= pick_d;
    scol_q    <= scol_d;
    srow_q    <= srow_d;
    cur_col_q <= cur_col_d;
    cur_row_q <= cur_row_d;
    nb_ok_q   <= nb_ok_d;
    open_q    <= open_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Visited map: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_q <= vis_mem[nb_addr];
  end

  // Path stack: one write port, one registered read port at the top.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  // A finished maze has an empty path stack.
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> depth_q == '0)
    else $error("maze finished with cells left on the stack");

  // The stack never holds more cells than the grid has.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= SD_W'(CELLS))
    else $error("path stack depth above the cell count");

  // Finishing happens only by popping the last cell.
  a_finish_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(depth_q) == SD_W'(1))
    else $error("maze finished without popping the last cell");

  // A result flagged done always reports the finished event.
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.maze_done) |-> out_q.event_kind == EV_FINISHED)
    else $error("done flag on a result that is not finished");

  // A carve is only issued from a probed open direction.
  a_carve_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && stk_we) |-> open_q[pick_q])
    else $error("carve into a neighbour that was not open");

endmodule
`default_nettype wire

>>> verif/maze_dfs_carver_tb.sv
// Self-checking testbench of the depth-first maze carver, with a behavioral predictor.
`timescale 1ns / 1ps
module maze_dfs_carver_tb;
  import mdc_pkg::*;

  localparam int unsigned Cols       = 32;
  localparam int unsigned Rows       = 32;
  localparam int unsigned Cells      = Cols * Rows;
  localparam int unsigned Period     = 10;
  localparam int unsigned QuietLimit = 20000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PlanLen    = 25;

  // One row of the directed walk: the word to send, and the result typed in
  // by hand where it is obvious; other rows are checked against the predictor.
  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t result;
  } plan_row_t;

  // The directed walk runs on a 5 by 4 grid. It starts from an out-of-range
  // cell, hits every grid border, runs into a visited cell and ends in a
  // chain of backtracks.
  localparam plan_row_t Plan [PlanLen] = '{
    '{'{DIR_LEFT,  5'd31, 5'd31}, 1'b1, '{EV_STARTED, 5'd4, 5'd3, 5'd0, 5'd0, 2'd0, 1'b0}},
    '{'{DIR_RIGHT, 5'd0,  5'd0},  1'b1, '{EV_BLOCKED, 5'd4, 5'd3, 5'd0, 5'd0, 2'd0, 1'b0}},
    '{'{DIR_DOWN,  5'd17, 5'd9},  1'b1, '{EV_BLOCKED, 5'd4, 5'd3, 5'd0, 5'd0, 2'd0, 1'b0}},
    '{'{DIR_UP,    5'd31, 5'd0},  1'b1, '{EV_CARVED,  5'd4, 5'd3, 5'd4, 5'd2, DIR_UP, 1'b0}},
    '{'{DIR_DOWN,  5'd0,  5'd31}, 1'b1, '{EV_BLOCKED, 5'd4, 5'd2, 5'd0, 5'd0, 2'd0, 1'b0}},
    '{'{DIR_LEFT,  5'd21, 5'd10}, 1'b0, '0},
    '{'{DIR_UP,    5'd10, 5'd21}, 1'b0, '0},
    '{'{DIR_UP,    5'd31, 5'd31}, 1'b0, '0},
    '{'{DIR_UP,    5'd0,  5'd0},  1'b0, '0},
    '{'{DIR_LEFT,  5'd21, 5'd10}, 1'b0, '0},
    '{'{DIR_LEFT,  5'd10, 5'd21}, 1'b0, '0},
    '{'{DIR_LEFT,  5'd31, 5'd31}, 1'b0, '0},
    '{'{DIR_LEFT,  5'd0,  5'd0},  1'b0, '0},
    '{'{DIR_DOWN,  5'd21, 5'd10}, 1'b0, '0},
    '{'{DIR_RIGHT, 5'd10, 5'd21}, 1'b0, '0},
    '{'{DIR_RIGHT, 5'd31, 5'd31}, 1'b0, '0},
    '{'{DIR_DOWN,  5'd0,  5'd0},  1'b0, '0},
    '{'{DIR_DOWN,  5'd21, 5'd10}, 1'b0, '0},
    '{'{DIR_LEFT,  5'd10, 5'd21}, 1'b0, '0},
    '{'{DIR_UP,    5'd31, 5'd31}, 1'b0, '0},
    '{'{DIR_LEFT,  5'd0,  5'd0},  1'b0, '0},
    '{'{DIR_DOWN,  5'd21, 5'd10}, 1'b0, '0},
    '{'{DIR_RIGHT, 5'd10, 5'd21}, 1'b0, '0},
    '{'{DIR_DOWN,  5'd31, 5'd31}, 1'b0, '0},
    '{'{DIR_UP,    5'd0,  5'd0},  1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_word;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  // Handshake of the two test processes: both are written with nonblocking
  // assignments so that the receiver never races with them.
  logic calm;
  logic hold_req;

  // Mirror of the carver state, kept by the predictor.
  bit            visited_q [Cells];
  int unsigned   path_q [Cells];
  int unsigned   depth_q;
  bit            finished_q;
  logic [5:0]    width_q;
  logic [5:0]    height_q;

  out_word_t     due_events [$];
  int unsigned   fault_n;
  int unsigned   quiet_n;

  maze_dfs_carver #(
    .MAX_COLUMNS(Cols),
    .MAX_ROWS   (Rows)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #(Period / 2) clk = ~clk;

  // A size of zero counts as one, a size above the maximum as the maximum.
  function automatic int unsigned eff_dim(logic [5:0] v, int unsigned maxv);
    if (v == 6'd0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  // True when the neighbour of (c, r) in direction d lies inside the grid in
  // use and has not been visited yet; its coordinates come back in nc, nr.
  function automatic bit free_cell(int unsigned c, int unsigned r, logic [1:0] d,
                                   output int unsigned nc, output int unsigned nr);
    int unsigned x;
    int unsigned y;
    x  = c;
    y  = r;
    nc = 0;
    nr = 0;
    case (d)
      DIR_UP: begin
        if (r == 0) return 1'b0;
        y = r - 1;
      end
      DIR_LEFT: begin
        if (c == 0) return 1'b0;
        x = c - 1;
      end
      DIR_RIGHT: x = c + 1;
      default:   y = r + 1;
    endcase
    if (x >= eff_dim(width_q, Cols) || y >= eff_dim(height_q, Rows)) return 1'b0;
    if (visited_q[y * Cols + x]) return 1'b0;
    nc = x;
    nr = y;
    return 1'b1;
  endfunction

  // One iteration of the backtracker: updates the mirrored state and returns
  // the result word that the carver must produce for this input word.
  function automatic out_word_t carve_step(in_word_t w);
    out_word_t   o;
    int unsigned sc;
    int unsigned sr;
    int unsigned top;
    int unsigned c;
    int unsigned r;
    int unsigned nc;
    int unsigned nr;
    int unsigned xc;
    int unsigned xr;
    bit          any;
    o   = '0;
    any = 1'b0;
    if (finished_q) begin
      o.event_kind = EV_FINISHED;
      o.maze_done  = 1'b1;
      return o;
    end
    if (depth_q == 0) begin
      // Empty stack: start the maze, saturating the start cell into the grid.
      sc = 32'(w.start_column);
      sr = 32'(w.start_row);
      if (sc > eff_dim(width_q, Cols) - 1) sc = eff_dim(width_q, Cols) - 1;
      if (sr > eff_dim(height_q, Rows) - 1) sr = eff_dim(height_q, Rows) - 1;
      top            = sr * Cols + sc;
      visited_q[top] = 1'b1;
      path_q[0]      = top;
      depth_q        = 1;
      o.event_kind   = EV_STARTED;
      o.from_column  = 5'(sc);
      o.from_row     = 5'(sr);
      return o;
    end
    top           = path_q[depth_q - 1];
    c             = top % Cols;
    r             = top / Cols;
    o.from_column = 5'(c);
    o.from_row    = 5'(r);
    for (int d = 0; d < 4; d++) begin
      if (free_cell(c, r, 2'(d), xc, xr)) any = 1'b1;
    end
    if (!any) begin
      // Dead end: pop the cell; the last pop finishes the maze.
      depth_q--;
      if (depth_q == 0) begin
        finished_q   = 1'b1;
        o.event_kind = EV_FINISHED;
        o.maze_done  = 1'b1;
      end else begin
        o.event_kind = EV_BACKTRACKED;
      end
      return o;
    end
    if (free_cell(c, r, w.pick_direction, nc, nr) && depth_q < Cells) begin
      visited_q[nr * Cols + nc] = 1'b1;
      path_q[depth_q]           = nr * Cols + nc;
      depth_q++;
      o.event_kind       = EV_CARVED;
      o.to_column        = 5'(nc);
      o.to_row           = 5'(nr);
      o.carved_direction = w.pick_direction;
      return o;
    end
    o.event_kind = EV_BLOCKED;
    return o;
  endfunction

  // A direction that carves from the current cell, if there is one. Most
  // random words use it, so that the walk gets deep into the grid instead
  // of mostly bouncing off visited cells.
  function automatic logic [1:0] open_pick();
    logic [1:0]  opts [$];
    int unsigned top;
    int unsigned xc;
    int unsigned xr;
    if (finished_q || depth_q == 0) return 2'($urandom_range(3));
    top = path_q[depth_q - 1];
    for (int d = 0; d < 4; d++) begin
      if (free_cell(top % Cols, top / Cols, 2'(d), xc, xr)) opts.push_back(2'(d));
    end
    if (opts.size() == 0) return 2'($urandom_range(3));
    return opts[$urandom_range(opts.size() - 1)];
  endfunction

  task automatic flag_fault(input string msg);
    if (fault_n < 10) $display("%0t: %s", $realtime, msg);
    fault_n++;
  endtask

  // Both grid registers are written back to back while the carver is idle or still clearing its visited map.
  task automatic set_grid(input logic [5:0] w, input logic [5:0] h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
    width_q  = w;
    height_q = h;
  endtask

  // Random sender gap, so that idle cycles land on every phase of the carver's iteration.
  task automatic sender_gap();
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Offers one word and holds it until the carver takes it. Stall is sampled
  // at the falling edge, where it already has the value of the next rising
  // edge. The expected word is queued at the edge of acceptance.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t hand_res);
    out_word_t predicted;
    bit        taken;
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    predicted = carve_step(w);
    due_events.push_back(typed ? hand_res : predicted);
  endtask

  task automatic send_random();
    in_word_t w;
    sender_gap();
    w.start_column   = 5'($urandom);
    w.start_row      = 5'($urandom);
    w.pick_direction = ($urandom_range(99) < 70) ? open_pick() : 2'($urandom_range(3));
    send_word(w, 1'b0, '0);
  endtask

  // The sender pauses until every expected word has come back, then gives
  // the carver time to settle before the grid is touched.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Receiver: random stalls, none while calm, and one long hold-off that
  // fills the carver up and backs up its input.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  // Result checker. A word seen at the falling edge with valid high and stall
  // low is taken at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_events.size() == 0) begin
        flag_fault("result word with nothing expected");
      end else if (out_word !== due_events[0]) begin
        flag_fault($sformatf({"mismatch: expected kind %0d from (%0d,%0d) to (%0d,%0d)",
                              " dir %0d done %0d, got kind %0d from (%0d,%0d)",
                              " to (%0d,%0d) dir %0d done %0d"},
                             due_events[0].event_kind, due_events[0].from_column,
                             due_events[0].from_row, due_events[0].to_column,
                             due_events[0].to_row, due_events[0].carved_direction,
                             due_events[0].maze_done, out_word.event_kind,
                             out_word.from_column, out_word.from_row, out_word.to_column,
                             out_word.to_row, out_word.carved_direction,
                             out_word.maze_done));
        void'(due_events.pop_front());
      end else begin
        void'(due_events.pop_front());
      end
    end
  end

  // Watchdog: cycles in which neither side moves a word. The clearing sweep
  // after reset and the long hold-off are both well inside the limit.
  always @(negedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_n = 0;
    end else begin
      quiet_n++;
    end
    if (quiet_n >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned after_n;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_word    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_WIDTH;
    cfg_data   <= '0;
    calm       <= 1'b0;
    hold_req   <= 1'b0;
    fault_n    = 0;
    quiet_n    = 0;
    after_n    = 0;
    depth_q    = 0;
    finished_q = 1'b0;
    width_q    = 6'd32;
    height_q   = 6'd32;
    for (int i = 0; i < Cells; i++) visited_q[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk on a small grid; configuration goes in during the sweep.
    set_grid(6'd5, 6'd4);
    for (int i = 0; i < PlanLen; i++) begin
      sender_gap();
      send_word(Plan[i].word, Plan[i].typed, Plan[i].result);
    end
    drain();

    // A single row: cells left on the stack outside it only see in-grid
    // neighbours, so the walk backs out to row zero and runs along it.
    set_grid(6'd32, 6'd1);
    repeat (150) send_random();
    drain();

    // A single column, with no idling on either side.
    calm <= 1'b1;
    set_grid(6'd1, 6'd32);
    repeat (150) send_random();
    drain();
    calm <= 1'b0;

    // Oversized registers count as the full grid. The receiver holds off
    // for a long stretch while words keep coming.
    hold_req <= 1'b1;
    set_grid(6'd63, 6'd63);
    repeat (300) send_random();
    drain();

    // A zero-sized grid counts as one cell: every iteration backtracks until
    // the stack runs dry and the maze finishes, then it stays finished.
    set_grid(6'd0, 6'd0);
    while (!finished_q || after_n < 50) begin
      send_random();
      if (finished_q) after_n++;
    end

    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fault_n == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/mdc_pkg.sv
hdl/maze_dfs_carver.sv
verif/maze_dfs_carver_tb.sv
